// ===== hdl/tphi_pkg.sv =====
// ----------------------------------------------------------------------------
// tphi_pkg: shared definitions for the triangle height interpolation unit
// Result status codes, the per-stage control word and fixed widths.
// ----------------------------------------------------------------------------
package tphi_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int LIMIT_WIDTH = 50;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(1);

   typedef enum logic [1:0] {
      STATUS_INSIDE     = 2'd0,
      STATUS_DEGENERATE = 2'd1,
      STATUS_OUTSIDE    = 2'd2
   } status_type;

   typedef struct packed {
      logic       valid;
      status_type status;
   } ctl_type;

endpackage

// ===== hdl/triangle_point_height_interp_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_point_height_interp_unit: barycentric height of a triangle at a point
// A request passes through tphi_geom, tphi_numer and tphi_div, then the final sum register
// and the output register, before its result shows on rsp_valid.
// Throughput: one request per cycle while the skid stage is empty; a two-entry output register and skid stage
// stop intake only when both hold results. Synchronous reset empties the
// pipeline and sets the degenerate limit to 1; csr writes are taken every cycle.
// ----------------------------------------------------------------------------
module triangle_point_height_interp_unit #(
   parameter int COORD_WIDTH = tphi_pkg::COORD_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex_a_x,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex_a_z,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex_a_y,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex_b_x,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex_b_z,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex_b_y,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex_c_x,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex_c_z,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex_c_y,
   input  logic signed [COORD_WIDTH-1:0]    req_point_x,
   input  logic signed [COORD_WIDTH-1:0]    req_point_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic signed [COORD_WIDTH-1:0]    rsp_height,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tphi_pkg::LIMIT_WIDTH-1:0] csr_wdata
);

   localparam int W = COORD_WIDTH;
   localparam logic signed [W+1:0] SAT_HI = (W+2)'((2 ** (W - 1)) - 1);
   localparam logic signed [W+1:0] SAT_LO = ~SAT_HI;

   logic                               en;
   logic [tphi_pkg::LIMIT_WIDTH-1:0]   limit_ff;

   tphi_pkg::ctl_type                  geo_ctl;
   logic [2*W:0]                       geo_den;
   logic signed [2*W+1:0]              geo_sn, geo_tn;
   logic signed [W:0]                  geo_dyb, geo_dyc;
   logic signed [W-1:0]                geo_ay;

   tphi_pkg::ctl_type                  num_ctl;
   logic [2*W:0]                       num_den;
   logic                               num_neg;
   logic [3*W:0]                       num_mag;
   logic signed [W-1:0]                num_ay;

   tphi_pkg::ctl_type                  div_ctl;
   logic                               div_neg;
   logic [W:0]                         div_q;
   logic signed [W-1:0]                div_ay;

   logic signed [W+1:0]                fin_sum;
   logic signed [W-1:0]                fin_sat;
   logic signed [W-1:0]                fin_height_in;
   tphi_pkg::ctl_type                  fin_ctl_ff;
   logic signed [W-1:0]                fin_height_ff;

   tphi_pkg::ctl_type                  out_ctl_ff, out_ctl_in;
   logic signed [W-1:0]                out_height_ff;
   tphi_pkg::ctl_type                  skid_ctl_ff, skid_ctl_in;
   logic signed [W-1:0]                skid_height_ff;
   logic                               emit;
   logic                               rsp_take;
   logic                               out_load_fin;
   logic                               out_load_skid;
   logic                               skid_load;

   // the whole pipeline advances while the skid stage is free
   assign en        = ~skid_ctl_ff.valid;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   tphi_geom #(.COORD_WIDTH(W)) u_geom (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .a_x      (req_vertex_a_x),
      .a_z      (req_vertex_a_z),
      .a_y      (req_vertex_a_y),
      .b_x      (req_vertex_b_x),
      .b_z      (req_vertex_b_z),
      .b_y      (req_vertex_b_y),
      .c_x      (req_vertex_c_x),
      .c_z      (req_vertex_c_z),
      .c_y      (req_vertex_c_y),
      .p_x      (req_point_x),
      .p_z      (req_point_z),
      .limit    (limit_ff),
      .out_ctl  (geo_ctl),
      .out_den  (geo_den),
      .out_sn   (geo_sn),
      .out_tn   (geo_tn),
      .out_dyb  (geo_dyb),
      .out_dyc  (geo_dyc),
      .out_ay   (geo_ay)
   );

   tphi_numer #(.COORD_WIDTH(W)) u_numer (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (geo_ctl),
      .in_den   (geo_den),
      .in_sn    (geo_sn),
      .in_tn    (geo_tn),
      .in_dyb   (geo_dyb),
      .in_dyc   (geo_dyc),
      .in_ay    (geo_ay),
      .out_ctl  (num_ctl),
      .out_den  (num_den),
      .out_neg  (num_neg),
      .out_mag  (num_mag),
      .out_ay   (num_ay)
   );

   tphi_div #(.COORD_WIDTH(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (num_ctl),
      .in_den   (num_den),
      .in_neg   (num_neg),
      .in_mag   (num_mag),
      .in_ay    (num_ay),
      .out_ctl  (div_ctl),
      .out_neg  (div_neg),
      .out_q    (div_q),
      .out_ay   (div_ay)
   );

   // add the signed rounded quotient to ay and clamp to the coordinate range; only an inside result keeps the height
   assign fin_sum = div_neg ? $signed((W+2)'(div_ay)) - $signed((W+2)'(div_q))
                            : $signed((W+2)'(div_ay)) + $signed((W+2)'(div_q));

   always_comb begin
      if (fin_sum > SAT_HI) begin
         fin_sat = SAT_HI[W-1:0];
      end else if (fin_sum < SAT_LO) begin
         fin_sat = SAT_LO[W-1:0];
      end else begin
         fin_sat = fin_sum[W-1:0];
      end
      fin_height_in = (div_ctl.status == tphi_pkg::STATUS_INSIDE) ? fin_sat : '0;
   end

   // output register with a skid stage behind it
   assign emit          = en & fin_ctl_ff.valid;
   assign rsp_take      = out_ctl_ff.valid & rsp_ready;
   assign out_load_skid = rsp_take & skid_ctl_ff.valid;
   assign out_load_fin  = emit & (rsp_take | ~out_ctl_ff.valid);
   assign skid_load     = emit & out_ctl_ff.valid & ~rsp_take;

   always_comb begin
      out_ctl_in = out_ctl_ff;
      if (out_load_skid) begin
         out_ctl_in = skid_ctl_ff;
      end else if (out_load_fin) begin
         out_ctl_in = fin_ctl_ff;
      end else if (rsp_take) begin
         out_ctl_in.valid = 1'b0;
      end

      skid_ctl_in = skid_ctl_ff;
      if (skid_load) begin
         skid_ctl_in = fin_ctl_ff;
      end else if (rsp_take) begin
         skid_ctl_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= tphi_pkg::LIMIT_RESET;
         fin_ctl_ff  <= '0;
         out_ctl_ff  <= '0;
         skid_ctl_ff <= '0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_wdata;
         end
         if (en) begin
            fin_ctl_ff <= div_ctl;
         end
         out_ctl_ff  <= out_ctl_in;
         skid_ctl_ff <= skid_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_height_ff <= fin_height_in;
      end
      if (out_load_skid) begin
         out_height_ff <= skid_height_ff;
      end else if (out_load_fin) begin
         out_height_ff <= fin_height_ff;
      end
      if (skid_load) begin
         skid_height_ff <= fin_height_ff;
      end
   end

   assign rsp_valid  = out_ctl_ff.valid;
   assign rsp_status = out_ctl_ff.status;
   assign rsp_height = out_height_ff;

endmodule

// ===== hdl/tphi_geom.sv =====
// ----------------------------------------------------------------------------
// tphi_geom: edge vectors, cross products and determinant test
// Four stages: differences, six products, den/s/t numerators, sign fold and
// degenerate compare against the programmed limit.
// ----------------------------------------------------------------------------
module tphi_geom #(
   parameter int COORD_WIDTH = tphi_pkg::COORD_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [COORD_WIDTH-1:0]        a_x,
   input  logic signed [COORD_WIDTH-1:0]        a_z,
   input  logic signed [COORD_WIDTH-1:0]        a_y,
   input  logic signed [COORD_WIDTH-1:0]        b_x,
   input  logic signed [COORD_WIDTH-1:0]        b_z,
   input  logic signed [COORD_WIDTH-1:0]        b_y,
   input  logic signed [COORD_WIDTH-1:0]        c_x,
   input  logic signed [COORD_WIDTH-1:0]        c_z,
   input  logic signed [COORD_WIDTH-1:0]        c_y,
   input  logic signed [COORD_WIDTH-1:0]        p_x,
   input  logic signed [COORD_WIDTH-1:0]        p_z,
   input  logic [tphi_pkg::LIMIT_WIDTH-1:0]     limit,
   output tphi_pkg::ctl_type                    out_ctl,
   output logic [2*COORD_WIDTH:0]               out_den,
   output logic signed [2*COORD_WIDTH+1:0]      out_sn,
   output logic signed [2*COORD_WIDTH+1:0]      out_tn,
   output logic signed [COORD_WIDTH:0]          out_dyb,
   output logic signed [COORD_WIDTH:0]          out_dyc,
   output logic signed [COORD_WIDTH-1:0]        out_ay
);

   localparam int W = COORD_WIDTH;
   localparam int D = W + 1;
   localparam int P = 2 * W + 2;
   localparam int M = 2 * W + 1;
   localparam int CMP_W = (M > tphi_pkg::LIMIT_WIDTH) ? M : tphi_pkg::LIMIT_WIDTH;

   // stage 1
   logic                v1_ff;
   logic signed [D-1:0] ux1_in, uz1_in, vx1_in, vz1_in, wx1_in, wz1_in;
   logic signed [D-1:0] ux1_ff, uz1_ff, vx1_ff, vz1_ff, wx1_ff, wz1_ff;
   logic signed [D-1:0] dyb1_in, dyc1_in, dyb1_ff, dyc1_ff;
   logic signed [W-1:0] ay1_ff;
   // stage 2
   logic                v2_ff;
   logic signed [P-1:0] dp2_in, dq2_in, sp2_in, sq2_in, tp2_in, tq2_in;
   logic signed [P-1:0] dp2_ff, dq2_ff, sp2_ff, sq2_ff, tp2_ff, tq2_ff;
   logic signed [D-1:0] dyb2_ff, dyc2_ff;
   logic signed [W-1:0] ay2_ff;
   // stage 3
   logic                v3_ff;
   logic signed [P-1:0] den3_in, sn3_in, tn3_in, den3_ff, sn3_ff, tn3_ff;
   logic signed [D-1:0] dyb3_ff, dyc3_ff;
   logic signed [W-1:0] ay3_ff;
   // stage 4
   tphi_pkg::ctl_type   ctl4_in, ctl4_ff;
   logic                den_neg;
   logic [P-1:0]        den_abs;
   logic                degenerate;
   logic [M-1:0]        den4_ff;
   logic signed [P-1:0] sn4_in, tn4_in, sn4_ff, tn4_ff;
   logic signed [D-1:0] dyb4_ff, dyc4_ff;
   logic signed [W-1:0] ay4_ff;

   assign ux1_in  = D'(b_x) - D'(a_x);
   assign uz1_in  = D'(b_z) - D'(a_z);
   assign vx1_in  = D'(c_x) - D'(a_x);
   assign vz1_in  = D'(c_z) - D'(a_z);
   assign wx1_in  = D'(p_x) - D'(a_x);
   assign wz1_in  = D'(p_z) - D'(a_z);
   assign dyb1_in = D'(b_y) - D'(a_y);
   assign dyc1_in = D'(c_y) - D'(a_y);

   assign dp2_in = ux1_ff * vz1_ff;
   assign dq2_in = vx1_ff * uz1_ff;
   assign sp2_in = wx1_ff * vz1_ff;
   assign sq2_in = vx1_ff * wz1_ff;
   assign tp2_in = ux1_ff * wz1_ff;
   assign tq2_in = wx1_ff * uz1_ff;

   assign den3_in = dp2_ff - dq2_ff;
   assign sn3_in  = sp2_ff - sq2_ff;
   assign tn3_in  = tp2_ff - tq2_ff;

   // fold the sign of den into the numerators so the inside test is plain
   assign den_neg    = den3_ff[P-1];
   assign den_abs    = den_neg ? P'(-den3_ff) : P'(den3_ff);
   assign sn4_in     = den_neg ? -sn3_ff : sn3_ff;
   assign tn4_in     = den_neg ? -tn3_ff : tn3_ff;
   assign degenerate = (den3_ff == '0) || (CMP_W'(den_abs[M-1:0]) < CMP_W'(limit));

   always_comb begin
      ctl4_in.valid  = v3_ff;
      ctl4_in.status = degenerate ? tphi_pkg::STATUS_DEGENERATE : tphi_pkg::STATUS_INSIDE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         ctl4_ff <= '0;
      end else if (en) begin
         v1_ff   <= in_valid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         ctl4_ff <= ctl4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux1_ff  <= ux1_in;
         uz1_ff  <= uz1_in;
         vx1_ff  <= vx1_in;
         vz1_ff  <= vz1_in;
         wx1_ff  <= wx1_in;
         wz1_ff  <= wz1_in;
         dyb1_ff <= dyb1_in;
         dyc1_ff <= dyc1_in;
         ay1_ff  <= a_y;

         dp2_ff  <= dp2_in;
         dq2_ff  <= dq2_in;
         sp2_ff  <= sp2_in;
         sq2_ff  <= sq2_in;
         tp2_ff  <= tp2_in;
         tq2_ff  <= tq2_in;
         dyb2_ff <= dyb1_ff;
         dyc2_ff <= dyc1_ff;
         ay2_ff  <= ay1_ff;

         den3_ff <= den3_in;
         sn3_ff  <= sn3_in;
         tn3_ff  <= tn3_in;
         dyb3_ff <= dyb2_ff;
         dyc3_ff <= dyc2_ff;
         ay3_ff  <= ay2_ff;

         den4_ff <= den_abs[M-1:0];
         sn4_ff  <= sn4_in;
         tn4_ff  <= tn4_in;
         dyb4_ff <= dyb3_ff;
         dyc4_ff <= dyc3_ff;
         ay4_ff  <= ay3_ff;
      end
   end

   assign out_ctl = ctl4_ff;
   assign out_den = den4_ff;
   assign out_sn  = sn4_ff;
   assign out_tn  = tn4_ff;
   assign out_dyb = dyb4_ff;
   assign out_dyc = dyc4_ff;
   assign out_ay  = ay4_ff;

endmodule

// ===== hdl/tphi_numer.sv =====
// ----------------------------------------------------------------------------
// tphi_numer: inside test and interpolation numerator
// Four stages: inside test with split partial products, partial sums,
// recombination, and sign/magnitude split of the numerator.
// ----------------------------------------------------------------------------
module tphi_numer #(
   parameter int COORD_WIDTH = tphi_pkg::COORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  tphi_pkg::ctl_type               in_ctl,
   input  logic [2*COORD_WIDTH:0]          in_den,
   input  logic signed [2*COORD_WIDTH+1:0] in_sn,
   input  logic signed [2*COORD_WIDTH+1:0] in_tn,
   input  logic signed [COORD_WIDTH:0]     in_dyb,
   input  logic signed [COORD_WIDTH:0]     in_dyc,
   input  logic signed [COORD_WIDTH-1:0]   in_ay,
   output tphi_pkg::ctl_type               out_ctl,
   output logic [2*COORD_WIDTH:0]          out_den,
   output logic                            out_neg,
   output logic [3*COORD_WIDTH:0]          out_mag,
   output logic signed [COORD_WIDTH-1:0]   out_ay
);

   localparam int W     = COORD_WIDTH;
   localparam int P     = 2 * W + 2;
   localparam int M     = 2 * W + 1;
   localparam int LO_W  = W + 1;
   localparam int HI_W  = M - LO_W;
   localparam int PP_W  = 2 * W + 3;
   localparam int SUM_W = PP_W + 1 + LO_W;
   localparam int NUM_W = 3 * W + 2;
   localparam int MAG_W = NUM_W - 1;

   // stage 5
   logic [P:0]              st_sum;
   logic                    outside;
   tphi_pkg::ctl_type       ctl5_in, ctl5_ff;
   logic signed [LO_W:0]    s_lo, t_lo;
   logic signed [HI_W:0]    s_hi, t_hi;
   logic signed [PP_W-1:0]  slo5_in, shi5_in, tlo5_in, thi5_in;
   logic signed [PP_W-1:0]  slo5_ff, shi5_ff, tlo5_ff, thi5_ff;
   logic [M-1:0]            den5_ff;
   logic signed [W-1:0]     ay5_ff;
   // stage 6
   tphi_pkg::ctl_type       ctl6_ff;
   logic signed [PP_W:0]    hi6_in, lo6_in, hi6_ff, lo6_ff;
   logic [M-1:0]            den6_ff;
   logic signed [W-1:0]     ay6_ff;
   // stage 7
   tphi_pkg::ctl_type       ctl7_ff;
   logic signed [SUM_W-1:0] full_sum;
   logic signed [NUM_W-1:0] num7_ff;
   logic [M-1:0]            den7_ff;
   logic signed [W-1:0]     ay7_ff;
   // stage 8
   tphi_pkg::ctl_type       ctl8_ff;
   logic                    neg8_in, neg8_ff;
   logic [NUM_W-1:0]        mag8_in;
   logic [MAG_W-1:0]        mag8_ff;
   logic [M-1:0]            den8_ff;
   logic signed [W-1:0]     ay8_ff;

   // inside when s >= 0, t >= 0 and s + t <= den, boundary included
   assign st_sum  = (P+1)'(in_sn) + (P+1)'(in_tn);
   assign outside = in_sn[P-1] | in_tn[P-1] | (st_sum > (P+1)'(in_den));

   always_comb begin
      ctl5_in = in_ctl;
      if (in_ctl.status == tphi_pkg::STATUS_INSIDE && outside) begin
         ctl5_in.status = tphi_pkg::STATUS_OUTSIDE;
      end
   end

   // split s and t into low and high halves to keep each multiplier narrow
   assign s_lo    = {1'b0, in_sn[LO_W-1:0]};
   assign s_hi    = {1'b0, in_sn[M-1:LO_W]};
   assign t_lo    = {1'b0, in_tn[LO_W-1:0]};
   assign t_hi    = {1'b0, in_tn[M-1:LO_W]};
   assign slo5_in = s_lo * in_dyb;
   assign shi5_in = s_hi * in_dyb;
   assign tlo5_in = t_lo * in_dyc;
   assign thi5_in = t_hi * in_dyc;

   assign hi6_in = shi5_ff + thi5_ff;
   assign lo6_in = slo5_ff + tlo5_ff;

   assign full_sum = (SUM_W'(hi6_ff) <<< LO_W) + SUM_W'(lo6_ff);

   assign neg8_in = num7_ff[NUM_W-1];
   assign mag8_in = neg8_in ? NUM_W'(-num7_ff) : NUM_W'(num7_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff <= '0;
         ctl6_ff <= '0;
         ctl7_ff <= '0;
         ctl8_ff <= '0;
      end else if (en) begin
         ctl5_ff <= ctl5_in;
         ctl6_ff <= ctl5_ff;
         ctl7_ff <= ctl6_ff;
         ctl8_ff <= ctl7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slo5_ff <= slo5_in;
         shi5_ff <= shi5_in;
         tlo5_ff <= tlo5_in;
         thi5_ff <= thi5_in;
         den5_ff <= in_den;
         ay5_ff  <= in_ay;

         hi6_ff  <= hi6_in;
         lo6_ff  <= lo6_in;
         den6_ff <= den5_ff;
         ay6_ff  <= ay5_ff;

         num7_ff <= full_sum[NUM_W-1:0];
         den7_ff <= den6_ff;
         ay7_ff  <= ay6_ff;

         neg8_ff <= neg8_in;
         mag8_ff <= mag8_in[MAG_W-1:0];
         den8_ff <= den7_ff;
         ay8_ff  <= ay7_ff;
      end
   end

   assign out_ctl = ctl8_ff;
   assign out_den = den8_ff;
   assign out_neg = neg8_ff;
   assign out_mag = mag8_ff;
   assign out_ay  = ay8_ff;

endmodule

// ===== hdl/tphi_div.sv =====
// ----------------------------------------------------------------------------
// tphi_div: pipelined restoring divider with round to nearest
// One quotient bit per stage over COORD_WIDTH stages, then a rounding stage
// that adds one when twice the remainder reaches the divisor.
// ----------------------------------------------------------------------------
module tphi_div #(
   parameter int COORD_WIDTH = tphi_pkg::COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  tphi_pkg::ctl_type             in_ctl,
   input  logic [2*COORD_WIDTH:0]        in_den,
   input  logic                          in_neg,
   input  logic [3*COORD_WIDTH:0]        in_mag,
   input  logic signed [COORD_WIDTH-1:0] in_ay,
   output tphi_pkg::ctl_type             out_ctl,
   output logic                          out_neg,
   output logic [COORD_WIDTH:0]          out_q,
   output logic signed [COORD_WIDTH-1:0] out_ay
);

   localparam int W     = COORD_WIDTH;
   localparam int M     = 2 * W + 1;
   localparam int MAG_W = 3 * W + 1;

   tphi_pkg::ctl_type   ctl_src [W];
   logic [M-1:0]        r_src   [W];
   logic [W-1:0]        qd_src  [W];
   logic [M-1:0]        den_src [W];
   logic                neg_src [W];
   logic signed [W-1:0] ay_src  [W];

   logic [M-1:0]        r_in    [W];
   logic [W-1:0]        qd_in   [W];

   tphi_pkg::ctl_type   ctl_ff  [W];
   logic [M-1:0]        r_ff    [W];
   logic [W-1:0]        qd_ff   [W];
   logic [M-1:0]        den_ff  [W];
   logic                neg_ff  [W];
   logic signed [W-1:0] ay_ff   [W];

   logic                round_up;
   logic [W:0]          q_in;
   tphi_pkg::ctl_type   rctl_ff;
   logic                rneg_ff;
   logic [W:0]          q_ff;
   logic signed [W-1:0] ray_ff;

   // the quotient is known to fit W bits, so the top of the dividend starts
   // below the divisor and W shift/subtract steps finish the job
   assign ctl_src[0] = in_ctl;
   assign r_src[0]   = in_mag[MAG_W-1:W];
   assign qd_src[0]  = in_mag[W-1:0];
   assign den_src[0] = in_den;
   assign neg_src[0] = in_neg;
   assign ay_src[0]  = in_ay;

   for (genvar k = 1; k < W; k++) begin : g_link
      assign ctl_src[k] = ctl_ff[k-1];
      assign r_src[k]   = r_ff[k-1];
      assign qd_src[k]  = qd_ff[k-1];
      assign den_src[k] = den_ff[k-1];
      assign neg_src[k] = neg_ff[k-1];
      assign ay_src[k]  = ay_ff[k-1];
   end

   for (genvar k = 0; k < W; k++) begin : g_step
      logic [M:0] trial;
      logic       fits;
      assign trial    = {r_src[k], qd_src[k][W-1]};
      assign fits     = trial >= {1'b0, den_src[k]};
      assign r_in[k]  = fits ? M'(trial - {1'b0, den_src[k]}) : trial[M-1:0];
      // shift out the next dividend bit, shift in the quotient bit
      assign qd_in[k] = {qd_src[k][W-2:0], fits};
   end

   assign round_up = {r_ff[W-1], 1'b0} >= {1'b0, den_ff[W-1]};
   assign q_in     = (W+1)'(qd_ff[W-1]) + (W+1)'(round_up);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < W; k++) begin
            ctl_ff[k] <= '0;
         end
         rctl_ff <= '0;
      end else if (en) begin
         for (int k = 0; k < W; k++) begin
            ctl_ff[k] <= ctl_src[k];
         end
         rctl_ff <= ctl_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < W; k++) begin
            r_ff[k]   <= r_in[k];
            qd_ff[k]  <= qd_in[k];
            den_ff[k] <= den_src[k];
            neg_ff[k] <= neg_src[k];
            ay_ff[k]  <= ay_src[k];
         end
         rneg_ff <= neg_ff[W-1];
         q_ff    <= q_in;
         ray_ff  <= ay_ff[W-1];
      end
   end

   assign out_ctl = rctl_ff;
   assign out_neg = rneg_ff;
   assign out_q   = q_ff;
   assign out_ay  = ray_ff;

endmodule

// ===== hdl/tphi_checker.sv =====
// ----------------------------------------------------------------------------
// tphi_checker: port-level checks for the triangle height interpolation unit
// Watches the request-ready and response ports; attached by bind below.
// ----------------------------------------------------------------------------
module tphi_checker #(
   parameter int COORD_WIDTH = tphi_pkg::COORD_WIDTH
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_status,
   input logic signed [COORD_WIDTH-1:0] rsp_height
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_height))
      else $error("response changed while stalled");

   // only a hit carries a height
   a_height_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != tphi_pkg::STATUS_INSIDE) |-> rsp_height == '0)
      else $error("nonzero height on a miss or degenerate triangle");

   // with the output register empty the skid stage is empty too
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with no result pending");

   // intake stops only after a held response met backpressure
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
      else $error("request ready dropped without response backpressure");

endmodule

bind triangle_point_height_interp_unit tphi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tphi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status),
   .rsp_height (rsp_height)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for triangle_point_height_interp_unit
// Sends triangle and point requests with random gaps and result back-pressure,
// predicts the status and interpolated height of each request in exact wide
// arithmetic and checks every result in order, over several degenerate limits.
// ----------------------------------------------------------------------------
module tb_top;
   import tphi_pkg::*;

   localparam int     PHASE_REQUESTS = 210;
   localparam int     CYCLE_LIMIT    = 200000;
   localparam int     DRAIN_CYCLES   = COORD_WIDTH + 20;
   localparam int     HI             = (1 <<< (COORD_WIDTH - 1)) - 1;
   localparam int     LO             = -HI - 1;
   localparam longint COORD_MAX      = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_MIN      = -COORD_MAX - 1;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_MAX = '1;

   typedef logic [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type ax, az, ay, bx, bz, by, cx, cz, cy, px, pz;
   } query_type;

   typedef struct packed {
      status_type status;
      coord_type  height;
   } height_result_type;

   typedef struct packed {
      query_type         query;
      logic              typed;
      height_result_type result;
   } stim_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [COORD_WIDTH-1:0] req_vertex_a_x, req_vertex_a_z, req_vertex_a_y;
   logic signed [COORD_WIDTH-1:0] req_vertex_b_x, req_vertex_b_z, req_vertex_b_y;
   logic signed [COORD_WIDTH-1:0] req_vertex_c_x, req_vertex_c_z, req_vertex_c_y;
   logic signed [COORD_WIDTH-1:0] req_point_x, req_point_z;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_status;
   logic signed [COORD_WIDTH-1:0] rsp_height;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [LIMIT_WIDTH-1:0]        csr_wdata;

   logic [LIMIT_WIDTH-1:0] limit_model;
   height_result_type      pending_heights [$];
   int                     error_count  = 0;
   int                     result_count = 0;
   int                     stall_left   = 0;
   int                     cycle_count;
   logic                   send_burst   = 1'b0;
   logic                   take_burst   = 1'b0;

   triangle_point_height_interp_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_vertex_a_x (req_vertex_a_x),
      .req_vertex_a_z (req_vertex_a_z),
      .req_vertex_a_y (req_vertex_a_y),
      .req_vertex_b_x (req_vertex_b_x),
      .req_vertex_b_z (req_vertex_b_z),
      .req_vertex_b_y (req_vertex_b_y),
      .req_vertex_c_x (req_vertex_c_x),
      .req_vertex_c_z (req_vertex_c_z),
      .req_vertex_c_y (req_vertex_c_y),
      .req_point_x    (req_point_x),
      .req_point_z    (req_point_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_height     (rsp_height),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------
   // Height predictor
   // ------------------------------------------------------------------
   function automatic logic signed [127:0] widen(input coord_type v);
      return signed'(v);
   endfunction

   function automatic height_result_type interpolate_height(input query_type q,
                                                           input logic [LIMIT_WIDTH-1:0] limit);
      logic signed [127:0] ay, ux, uz, vx, vz, wx, wz, den, sn, tn, span;
      logic signed [127:0] acc, quo, rem, hgt, hi_lim, lo_lim;
      logic                neg;
      height_result_type   res;
      ay   = widen(q.ay);
      ux   = widen(q.bx) - widen(q.ax);
      uz   = widen(q.bz) - widen(q.az);
      vx   = widen(q.cx) - widen(q.ax);
      vz   = widen(q.cz) - widen(q.az);
      wx   = widen(q.px) - widen(q.ax);
      wz   = widen(q.pz) - widen(q.az);
      den  = ux * vz - vx * uz;
      sn   = wx * vz - vx * wz;
      tn   = ux * wz - wx * uz;
      span = (den < 0) ? -den : den;
      res.status = STATUS_DEGENERATE;
      res.height = '0;
      if (den == 0 || span < signed'({78'd0, limit}))
         return res;
      // normalize to a positive determinant so the inside test is by sign
      if (den < 0) begin
         den = -den;
         sn  = -sn;
         tn  = -tn;
      end
      res.status = STATUS_OUTSIDE;
      if (sn < 0 || tn < 0 || sn > den - tn)
         return res;
      acc = sn * (widen(q.by) - ay) + tn * (widen(q.cy) - ay);
      neg = acc < 0;
      if (neg)
         acc = -acc;
      quo = acc / den;
      rem = acc - quo * den;
      // round the magnitude half up, i.e. ties away from zero
      if (2 * rem >= den)
         quo = quo + 1;
      if (quo > (128'sd1 <<< 40))
         quo = 128'sd1 <<< 40;
      hgt    = neg ? ay - quo : ay + quo;
      hi_lim = (128'sd1 <<< (COORD_WIDTH - 1)) - 1;
      lo_lim = -hi_lim - 1;
      if (hgt > hi_lim)
         hgt = hi_lim;
      if (hgt < lo_lim)
         hgt = lo_lim;
      res.status = STATUS_INSIDE;
      res.height = hgt[COORD_WIDTH-1:0];
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic stim_row_type stim_row(input int ax, az, ay, bx, bz, by,
                                             input int cx, cz, cy, px, pz,
                                             input logic typed, input status_type st,
                                             input int h);
      stim_row_type r;
      r.query.ax      = coord_type'(ax);
      r.query.az      = coord_type'(az);
      r.query.ay      = coord_type'(ay);
      r.query.bx      = coord_type'(bx);
      r.query.bz      = coord_type'(bz);
      r.query.by      = coord_type'(by);
      r.query.cx      = coord_type'(cx);
      r.query.cz      = coord_type'(cz);
      r.query.cy      = coord_type'(cy);
      r.query.px      = coord_type'(px);
      r.query.pz      = coord_type'(pz);
      r.typed         = typed;
      r.result.status = st;
      r.result.height = coord_type'(h);
      return r;
   endfunction

   function automatic longint clamp_coord(input longint v);
      if (v > COORD_MAX)
         return COORD_MAX;
      if (v < COORD_MIN)
         return COORD_MIN;
      return v;
   endfunction

   function automatic longint any_coord();
      return longint'(signed'(coord_type'($urandom)));
   endfunction

   function automatic longint jitter(input int span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic query_type random_query();
      query_type q;
      longint    ax, az, ay, bx, bz, by, cx, cz, cy, px, pz, dx, dz;
      int        span, kind, wa, wb;
      kind = $urandom_range(0, 9);
      span = 1 << $urandom_range(0, COORD_WIDTH - 1);
      ax   = any_coord();
      az   = any_coord();
      ay   = any_coord();
      bx   = clamp_coord(ax + jitter(span));
      bz   = clamp_coord(az + jitter(span));
      cx   = clamp_coord(ax + jitter(span));
      cz   = clamp_coord(az + jitter(span));
      if ($urandom_range(0, 1)) begin
         by = any_coord();
         cy = any_coord();
      end else begin
         by = clamp_coord(ay + jitter(span));
         cy = clamp_coord(ay + jitter(span));
      end
      case (kind)
         0, 1, 2, 3: begin
            // mostly inside: a weighted blend of edge vectors AB and AC
            wa = $urandom_range(0, 1024);
            wb = $urandom_range(0, 1024 - wa);
            px = ax + ((bx - ax) * wa + (cx - ax) * wb) / 1024;
            pz = az + ((bz - az) * wa + (cz - az) * wb) / 1024;
         end
         4: begin
            // land exactly on a vertex or on the midpoint of edge AB
            dx = jitter(span / 2);
            dz = jitter(span / 2);
            bx = clamp_coord(ax + 2 * dx);
            bz = clamp_coord(az + 2 * dz);
            case ($urandom_range(0, 2))
               0: begin
                  px = ax;
                  pz = az;
               end
               1: begin
                  px = cx;
                  pz = cz;
               end
               default: begin
                  px = ax + dx;
                  pz = az + dz;
               end
            endcase
         end
         5, 6: begin
            px = ax + jitter(span);
            pz = az + jitter(span);
         end
         7: begin
            // collinear or coincident vertices
            wa = $urandom_range(0, 3) - 1;
            cx = clamp_coord(ax + (bx - ax) * wa);
            cz = clamp_coord(az + (bz - az) * wa);
            px = ax + jitter(span);
            pz = az + jitter(span);
         end
         8: begin
            // sliver: C just off B, small determinant against the limit
            cx = clamp_coord(bx + longint'($urandom_range(0, 6)) - 3);
            cz = clamp_coord(bz + longint'($urandom_range(0, 6)) - 3);
            px = ax + jitter(span);
            pz = az + jitter(span);
         end
         default: begin
            bx = any_coord();
            bz = any_coord();
            cx = any_coord();
            cz = any_coord();
            px = any_coord();
            pz = any_coord();
         end
      endcase
      q.ax = coord_type'(ax);
      q.az = coord_type'(az);
      q.ay = coord_type'(ay);
      q.bx = coord_type'(bx);
      q.bz = coord_type'(bz);
      q.by = coord_type'(by);
      q.cx = coord_type'(cx);
      q.cz = coord_type'(cz);
      q.cy = coord_type'(cy);
      q.px = coord_type'(clamp_coord(px));
      q.pz = coord_type'(clamp_coord(pz));
      return q;
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   task automatic send_query(input stim_row_type r);
      int                gap;
      height_result_type expect_res;
      gap = send_burst ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_vertex_a_x <= r.query.ax;
      req_vertex_a_z <= r.query.az;
      req_vertex_a_y <= r.query.ay;
      req_vertex_b_x <= r.query.bx;
      req_vertex_b_z <= r.query.bz;
      req_vertex_b_y <= r.query.by;
      req_vertex_c_x <= r.query.cx;
      req_vertex_c_z <= r.query.cz;
      req_vertex_c_y <= r.query.cy;
      req_point_x    <= r.query.px;
      req_point_z    <= r.query.pz;
      do @(posedge clock); while (!req_ready);
      expect_res      = r.typed ? r.result : interpolate_height(r.query, limit_model);
      pending_heights = {pending_heights, expect_res};
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_heights.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      limit_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Result checker and back-pressure
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      height_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_heights.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none actual status %0d height %0d",
                     $time, rsp_status, rsp_height);
         end else begin
            want = pending_heights.pop_front();
            if (rsp_status !== want.status) begin
               error_count++;
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_status);
            end
            if (rsp_height !== want.height) begin
               error_count++;
               $display("%0t: height mismatch: expected %0d actual %0d",
                        $time, $signed(want.height), rsp_height);
            end
         end
         if (result_count % 40 == 0)
            take_burst = ($urandom_range(0, 3) == 0);
         result_count++;
         stall_left = take_burst ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
         stall_left--;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= (stall_left == 0);
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      stim_row_type           rows [$];
      stim_row_type           draw;
      logic [LIMIT_WIDTH-1:0] plan [$];
      int                     n, p;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_vertex_a_x = '0;
      req_vertex_a_z = '0;
      req_vertex_a_y = '0;
      req_vertex_b_x = '0;
      req_vertex_b_z = '0;
      req_vertex_b_y = '0;
      req_vertex_c_x = '0;
      req_vertex_c_z = '0;
      req_vertex_c_y = '0;
      req_point_x    = '0;
      req_point_z    = '0;
      csr_valid      = 1'b0;
      csr_wdata      = '0;
      limit_model    = LIMIT_RESET;

      // zero-area triangle
      rows = {rows, stim_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, STATUS_DEGENERATE, 0)};
      // right triangle: each vertex, points outside edges AC and BC, on edge BC and inside
      rows = {rows, stim_row(0, 0, 100, 256, 0, 356, 0, 256, -50, 0, 0,
                             1, STATUS_INSIDE, 100)};
      rows = {rows, stim_row(0, 0, 100, 256, 0, 356, 0, 256, -50, 256, 0,
                             1, STATUS_INSIDE, 356)};
      rows = {rows, stim_row(0, 0, 100, 256, 0, 356, 0, 256, -50, 0, 256,
                             1, STATUS_INSIDE, -50)};
      rows = {rows, stim_row(0, 0, 100, 256, 0, 356, 0, 256, -50, -1, 0,
                             1, STATUS_OUTSIDE, 0)};
      rows = {rows, stim_row(0, 0, 100, 256, 0, 356, 0, 256, -50, 200, 200,
                             1, STATUS_OUTSIDE, 0)};
      rows = {rows, stim_row(0, 0, 100, 256, 0, 356, 0, 256, -50, 128, 128,
                             0, STATUS_INSIDE, 0)};
      rows = {rows, stim_row(0, 0, 100, 256, 0, 356, 0, 256, -50, 37, 201,
                             0, STATUS_INSIDE, 0)};
      // clockwise winding, negative determinant
      rows = {rows, stim_row(0, 0, 100, 0, 256, 356, 256, 0, -50, 10, 10,
                             0, STATUS_INSIDE, 0)};
      // collinear, then coincident vertices
      rows = {rows, stim_row(0, 0, 5, 256, 256, 7, 512, 512, 9, 0, 0,
                             1, STATUS_DEGENERATE, 0)};
      rows = {rows, stim_row(7, 7, 1, 7, 7, 2, 300, -40, 3, 7, 7,
                             1, STATUS_DEGENERATE, 0)};
      // quotient exactly one half, positive and negative
      rows = {rows, stim_row(0, 0, 0, 2, 0, 1, 0, 2, 0, 1, 0, 0, STATUS_INSIDE, 0)};
      rows = {rows, stim_row(0, 0, 0, 2, 0, -1, 0, 2, 0, 1, 0, 0, STATUS_INSIDE, 0)};
      // smallest nonzero determinant
      rows = {rows, stim_row(0, 0, 0, 1, 0, HI, 0, 1, LO, 0, 0, 1, STATUS_INSIDE, 0)};
      // full-scale triangle
      rows = {rows, stim_row(LO, LO, LO, HI, LO, HI, LO, HI, HI, 0, 0,
                             0, STATUS_INSIDE, 0)};
      rows = {rows, stim_row(LO, LO, LO, HI, LO, HI, LO, HI, HI, HI, HI,
                             1, STATUS_OUTSIDE, 0)};
      rows = {rows, stim_row(LO, LO, LO, HI, LO, HI, LO, HI, HI, LO, LO,
                             1, STATUS_INSIDE, LO)};
      rows = {rows, stim_row(LO, LO, LO, HI, LO, HI, LO, HI, HI, HI, LO,
                             1, STATUS_INSIDE, HI)};
      rows = {rows, stim_row(LO, LO, LO, HI, LO, HI, LO, HI, HI, -1, 5,
                             0, STATUS_INSIDE, 0)};
      rows = {rows, stim_row(HI, HI, HI, HI, HI, HI, HI, HI, HI, HI, HI,
                             1, STATUS_DEGENERATE, 0)};
      rows = {rows, stim_row(LO, LO, LO, LO, LO, LO, LO, LO, LO, LO, LO,
                             1, STATUS_DEGENERATE, 0)};

      plan = {plan, LIMIT_WIDTH'(0)};
      plan = {plan, LIMIT_MAX};
      plan = {plan, LIMIT_WIDTH'(1) << 12};
      plan = {plan, LIMIT_WIDTH'(1) << 30};
      plan = {plan, LIMIT_WIDTH'({$urandom, $urandom} >> $urandom_range(14, 63))};
      plan = {plan, LIMIT_RESET};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_query(rows[i]);

      draw.typed  = 1'b0;
      draw.result = '0;
      for (p = 0; p <= plan.size(); p++) begin
         // change the limit only with the pipeline empty
         if (p > 0) begin
            hold_until_drained();
            write_limit(plan[p-1]);
         end
         for (n = 0; n < PHASE_REQUESTS; n++) begin
            if (n % 40 == 0)
               send_burst = ($urandom_range(0, 3) == 0);
            draw.query = random_query();
            send_query(draw);
         end
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
